// ----- rtl/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, codes and constants of the timestamp clock sync model.
// ----------------------------------------------------------------------------
package tcs_pkg;

	localparam int TS_BITS = 40;

	// item kinds
	localparam logic [1:0] FUNC_OBSERVE = 2'd0;
	localparam logic [1:0] FUNC_MISS    = 2'd1;
	localparam logic [1:0] FUNC_QUERY   = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_PHASE_SHIFT    = 3'd0;
	localparam logic [2:0] CFG_BASELINE_LIMIT = 3'd1;
	localparam logic [2:0] CFG_MISS_LIMIT     = 3'd2;
	localparam logic [2:0] CFG_JITTER_TICKS   = 3'd3;

	// shared unit operations
	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	// arithmetic constants
	localparam logic [13:0] K_JITTER_SCALE = 14'd14142;
	localparam logic [13:0] K_JITTER_DIV   = 14'd10000;
	localparam logic [29:0] K_NANO         = 30'd1000000000;
	localparam logic [19:0] K_MICRO        = 20'd1000000;
	localparam logic [9:0]  K_MILLI        = 10'd1000;

	typedef struct packed {
		logic [1:0]         func;
		logic [TS_BITS-1:0] master_ts;
		logic [TS_BITS-1:0] local_ts;
		logic [31:0]        ahead_ticks;
	} item_t;

	typedef struct packed {
		logic [TS_BITS-1:0] master_est;
		logic               convert_ok;
		logic [31:0]        error_ticks;
		logic signed [31:0] drift_ppb;
		logic               model_valid;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [1:0]  op;
		logic [63:0] a;
		logic [63:0] b;
	} tcs_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} tcs_rsp_t;

endpackage

// ----- rtl/tcs_iter.sv -----
// ----------------------------------------------------------------------------
// tcs_iter
// Bit-serial arithmetic unit: 64-bit low multiply, unsigned divide, root.
// ----------------------------------------------------------------------------
module tcs_iter import tcs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tcs_req_t req,
	output tcs_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [1:0]  op_q;
	logic [6:0]  cnt_q;
	logic [63:0] x_q, y_q, acc_q, b_q;

	logic [64:0] div_sh, div_diff;
	logic [63:0] sq_t;
	logic [6:0]  last_cnt;

	always_comb begin
		div_sh   = {acc_q, y_q[63]};
		div_diff = div_sh - {1'b0, b_q};
		sq_t     = acc_q + b_q;
		last_cnt = (op_q == OP_SQRT) ? 7'd31 : 7'd63;
	end

	// control: run a fixed number of steps, then pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == last_cnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: one add or subtract per step
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			case (req.op)
				OP_MUL: begin
					x_q   <= req.a;
					y_q   <= req.b;
					acc_q <= '0;
				end
				OP_DIV: begin
					y_q   <= req.a;
					b_q   <= req.b;
					acc_q <= '0;
				end
				default: begin
					x_q   <= req.a;
					acc_q <= '0;
					b_q   <= 64'h4000_0000_0000_0000;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					if (y_q[0]) acc_q <= acc_q + x_q;
					x_q <= {x_q[62:0], 1'b0};
					y_q <= {1'b0, y_q[63:1]};
				end
				OP_DIV: begin
					if (!div_diff[64]) begin
						acc_q <= div_diff[63:0];
						y_q   <= {y_q[62:0], 1'b1};
					end else begin
						acc_q <= div_sh[63:0];
						y_q   <= {y_q[62:0], 1'b0};
					end
				end
				default: begin
					if (x_q >= sq_t) begin
						x_q   <= x_q - sq_t;
						acc_q <= {1'b0, acc_q[63:1]} + b_q;
					end else begin
						acc_q <= {1'b0, acc_q[63:1]};
					end
					b_q <= {2'b00, b_q[63:2]};
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = (op_q == OP_DIV) ? y_q : acc_q;

endmodule

// ----- rtl/timestamp_clock_sync_model.sv -----
// ----------------------------------------------------------------------------
// timestamp_clock_sync_model
// Local-to-master timestamp conversion with drift and error tracking.
// ----------------------------------------------------------------------------
// One item is in work at a time. item_stall is high from the transfer until
// the result is loaded into the output register, and the block returns to
// idle before it takes the next item. In the shared bit-serial unit a 64-bit
// multiply or divide runs 64 steps. An item holds item_stall longest for an
// observe that converts, less for a query or miss that converts, less again
// when the model is valid but cannot convert and least when it is invalid.
// An observe runs at most four multiplies, five divides and two roots in
// sequence. A span of 2^50 ticks or more skips the rate divide, an oversized
// rate or sum of squares skips the final root, and an invalid model or zero
// master span skips the drift multiply and divide. A finished result waits in
// the output register while the next item is taken; an item that finishes
// while that register is still stalled waits until it is free. No clearing
// pass follows reset.
module timestamp_clock_sync_model import tcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_PRE   = 5'd1;
	localparam logic [4:0] ST_CMUL  = 5'd2;
	localparam logic [4:0] ST_CDIV  = 5'd3;
	localparam logic [4:0] ST_SPAN  = 5'd4;
	localparam logic [4:0] ST_HALF  = 5'd5;
	localparam logic [4:0] ST_CONV  = 5'd6;
	localparam logic [4:0] ST_EMUL  = 5'd7;
	localparam logic [4:0] ST_EDIV2 = 5'd8;
	localparam logic [4:0] ST_ESQ1  = 5'd9;
	localparam logic [4:0] ST_EDIV3 = 5'd10;
	localparam logic [4:0] ST_EFIN  = 5'd11;
	localparam logic [4:0] ST_ESQ2  = 5'd12;
	localparam logic [4:0] ST_DRIFT = 5'd13;
	localparam logic [4:0] ST_DMUL  = 5'd14;
	localparam logic [4:0] ST_DDIV  = 5'd15;
	localparam logic [4:0] ST_DONE  = 5'd16;

	function automatic logic [63:0] wdelta(input logic [TS_BITS-1:0] a,
	                                       input logic [TS_BITS-1:0] b);
		logic [TS_BITS-1:0] t;
		t = a - b;
		return {{(64-TS_BITS){t[TS_BITS-1]}}, t};
	endfunction

	function automatic logic [63:0] absv(input logic [63:0] x);
		return x[63] ? 64'd0 - x : x;
	endfunction

	// configuration
	logic [4:0]  phase_shift_q;
	logic [15:0] baseline_limit_q, miss_limit_q, jitter_q;

	// model state
	logic [TS_BITS-1:0] last_local_q, last_master_q;
	logic [63:0]        ls_q, ms_q, phase_q;
	logic [15:0]        obs_q, miss_q;
	logic               have_first_q, valid_q;

	// sequencer
	logic [4:0]         state_q;
	logic               launched_q, for_phase_q;
	item_t              it_q;
	logic [63:0]        prod_q, tmp_q, rate_q;
	logic [15:0]        pt_q;
	logic [TS_BITS-1:0] est_q;
	logic               ok_q;
	logic [31:0]        err_q;
	logic [31:0]        drift_q;
	logic               res_valid_q;
	result_t            result_q;

	tcs_req_t req;
	tcs_rsp_t rsp;

	logic               usable;
	logic [63:0]        d_conv, corr, est_full, q_sig, new_ls, ls_abs;
	logic [TS_BITS-1:0] est_w;
	logic [29:0]        jk;
	logic [61:0]        jprod;
	logic [63:0]        sr;
	logic [31:0]        sp;
	logic [64:0]        sq_sum;
	logic [15:0]        miss_inc, obs_inc;
	logic               d_neg;

	tcs_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// derive step values
	always_comb begin
		usable   = valid_q && (ls_q != 64'd0) && (miss_q <= miss_limit_q);
		d_conv   = wdelta(it_q.local_ts, last_local_q);
		q_sig    = (prod_q[63] ^ ls_q[63]) ? 64'd0 - rsp.res : rsp.res;
		corr     = q_sig;
		est_full = {{(64-TS_BITS){1'b0}}, last_master_q} + d_conv + corr + phase_q;
		est_w    = est_full[TS_BITS-1:0];
		ls_abs   = absv(ls_q);
		jk       = 30'(jitter_q) * 30'(K_JITTER_SCALE);
		jprod    = 62'(jk) * 62'(it_q.ahead_ticks);
		sr       = 64'(rate_q[31:0]) * 64'(rate_q[31:0]);
		sp       = 32'(pt_q) * 32'(pt_q);
		sq_sum   = {1'b0, sr} + {33'd0, sp};
		new_ls   = ls_q + wdelta(it_q.local_ts, last_local_q);
		miss_inc = (miss_q == 16'hFFFF) ? miss_q : miss_q + 16'd1;
		obs_inc  = (obs_q == 16'hFFFF) ? obs_q : obs_q + 16'd1;
		// a positive quotient of 2^63 wraps to the most negative value
		d_neg    = (prod_q[63] ^ ms_q[63]) | rsp.res[63];
	end

	// issue operands to the shared unit
	always_comb begin
		req = '0;
		case (state_q)
			ST_CMUL: begin
				req.op = OP_MUL;
				req.a  = d_conv;
				req.b  = ms_q - ls_q;
			end
			ST_CDIV: begin
				req.op = OP_DIV;
				req.a  = absv(prod_q);
				req.b  = absv(ls_q);
			end
			ST_EMUL: begin
				req.op = OP_MUL;
				req.a  = ls_abs;
				req.b  = 64'(K_JITTER_DIV);
			end
			ST_EDIV2: begin
				req.op = OP_DIV;
				req.a  = {2'b00, jprod};
				req.b  = tmp_q;
			end
			ST_ESQ1: begin
				req.op = OP_SQRT;
				req.a  = 64'(K_MICRO) << phase_shift_q;
			end
			ST_EDIV3: begin
				req.op = OP_DIV;
				req.a  = 64'(jitter_q) * 64'(K_MILLI);
				req.b  = tmp_q;
			end
			ST_ESQ2: begin
				req.op = OP_SQRT;
				req.a  = tmp_q;
			end
			ST_DMUL: begin
				req.op = OP_MUL;
				req.a  = ls_q - ms_q;
				req.b  = 64'(K_NANO);
			end
			ST_DDIV: begin
				req.op = OP_DIV;
				req.a  = absv(prod_q);
				req.b  = absv(ms_q);
			end
			default: req.op = OP_MUL;
		endcase
		req.start = !launched_q && (state_q inside {ST_CMUL, ST_CDIV, ST_EMUL, ST_EDIV2,
			ST_ESQ1, ST_EDIV3, ST_ESQ2, ST_DMUL, ST_DDIV});
	end

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_shift_q    <= 5'd4;
			baseline_limit_q <= 16'd128;
			miss_limit_q     <= 16'd3;
			jitter_q         <= 16'd64;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PHASE_SHIFT:    phase_shift_q    <= cfg_data[4:0];
				CFG_BASELINE_LIMIT: baseline_limit_q <= cfg_data;
				CFG_MISS_LIMIT:     miss_limit_q     <= cfg_data;
				CFG_JITTER_TICKS:   jitter_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequence the update and the three estimates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			launched_q   <= 1'b0;
			for_phase_q  <= 1'b0;
			res_valid_q  <= 1'b0;
			last_local_q <= '0;
			last_master_q <= '0;
			ls_q         <= '0;
			ms_q         <= '0;
			phase_q      <= '0;
			obs_q        <= '0;
			miss_q       <= '0;
			have_first_q <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			if (req.start) launched_q <= 1'b1;
			if (rsp.done) launched_q <= 1'b0;
			if (res_valid_q && !result_stall && state_q != ST_DONE) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_valid) state_q <= ST_PRE;
				end
				ST_PRE: begin
					state_q <= ST_CONV;
					case (it_q.func)
						FUNC_OBSERVE: begin
							if (!have_first_q) begin
								last_local_q  <= it_q.local_ts;
								last_master_q <= it_q.master_ts;
								have_first_q  <= 1'b1;
								miss_q        <= '0;
							end else if (usable) begin
								for_phase_q <= 1'b1;
								state_q     <= ST_CMUL;
							end else begin
								state_q <= ST_SPAN;
							end
						end
						FUNC_MISS: begin
							miss_q <= miss_inc;
							if (miss_inc > miss_limit_q) valid_q <= 1'b0;
						end
						default: ;
					endcase
				end
				ST_CMUL: begin
					if (rsp.done) begin
						prod_q  <= rsp.res;
						state_q <= ST_CDIV;
					end
				end
				ST_CDIV: begin
					if (rsp.done) begin
						if (for_phase_q) begin
							phase_q <= phase_q + 64'($signed(wdelta(it_q.master_ts, est_w))
								>>> phase_shift_q);
							state_q <= ST_SPAN;
						end else begin
							est_q   <= est_w;
							state_q <= ST_EMUL;
						end
					end
				end
				ST_SPAN: begin
					ls_q          <= new_ls;
					ms_q          <= ms_q + wdelta(it_q.master_ts, last_master_q);
					last_local_q  <= it_q.local_ts;
					last_master_q <= it_q.master_ts;
					miss_q        <= '0;
					obs_q         <= obs_inc;
					if (new_ls != 64'd0) valid_q <= 1'b1;
					state_q       <= ST_HALF;
				end
				ST_HALF: begin
					// halve toward zero
					if (obs_q >= baseline_limit_q) begin
						ls_q  <= 64'($signed(ls_q + {63'd0, ls_q[63]}) >>> 1);
						ms_q  <= 64'($signed(ms_q + {63'd0, ms_q[63]}) >>> 1);
						obs_q <= {1'b0, obs_q[15:1]};
					end
					state_q <= ST_CONV;
				end
				ST_CONV: begin
					for_phase_q <= 1'b0;
					ok_q        <= usable;
					if (usable) begin
						state_q <= ST_CMUL;
					end else begin
						est_q   <= '0;
						err_q   <= '1;
						state_q <= ST_DRIFT;
					end
				end
				ST_EMUL: begin
					// scale the span by the jitter divisor; a span of 2^50 or more
					// exceeds any jitter product, so the rate term is zero
					if (rsp.done) begin
						if (ls_abs[63:50] != 14'd0) begin
							rate_q  <= '0;
							state_q <= ST_ESQ1;
						end else begin
							tmp_q   <= rsp.res;
							state_q <= ST_EDIV2;
						end
					end
				end
				ST_EDIV2: begin
					if (rsp.done) begin
						rate_q  <= rsp.res;
						state_q <= ST_ESQ1;
					end
				end
				ST_ESQ1: begin
					if (rsp.done) begin
						tmp_q   <= rsp.res;
						state_q <= ST_EDIV3;
					end
				end
				ST_EDIV3: begin
					if (rsp.done) begin
						pt_q    <= rsp.res[15:0];
						state_q <= ST_EFIN;
					end
				end
				ST_EFIN: begin
					if (rate_q[63:32] != 32'd0 || sq_sum[64]) begin
						err_q   <= '1;
						state_q <= ST_DRIFT;
					end else begin
						tmp_q   <= sq_sum[63:0];
						state_q <= ST_ESQ2;
					end
				end
				ST_ESQ2: begin
					if (rsp.done) begin
						err_q   <= (rsp.res[63:32] != 32'd0) ? '1 : rsp.res[31:0];
						state_q <= ST_DRIFT;
					end
				end
				ST_DRIFT: begin
					if (!valid_q || ms_q == 64'd0) begin
						drift_q <= '0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DMUL;
					end
				end
				ST_DMUL: begin
					if (rsp.done) begin
						prod_q  <= rsp.res;
						state_q <= ST_DDIV;
					end
				end
				ST_DDIV: begin
					if (rsp.done) begin
						// saturate to the signed 32-bit range
						if (d_neg ? (rsp.res > 64'h8000_0000)
								: (rsp.res > 64'h7FFF_FFFF)) begin
							drift_q <= d_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
						end else begin
							drift_q <= 32'(d_neg ? 64'd0 - rsp.res : rsp.res);
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || !result_stall) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the item and load the result register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) it_q <= item;
		if (state_q == ST_DONE && (!res_valid_q || !result_stall)) begin
			result_q.master_est  <= est_q;
			result_q.convert_ok  <= ok_q;
			result_q.error_ticks <= err_q;
			result_q.drift_ppb   <= drift_q;
			result_q.model_valid <= valid_q;
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

endmodule

// ----- rtl/tcs_checker.sv -----
// ----------------------------------------------------------------------------
// tcs_checker
// Port-level checks of the timestamp clock sync model, bound to the top.
// ----------------------------------------------------------------------------
module tcs_checker import tcs_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// hold a stalled transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// drop the estimate when conversion fails
	a_est_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.convert_ok |-> result.master_est == '0)
		else $error("estimate not zero without conversion");

	a_err_ones: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.convert_ok |-> result.error_ticks == '1)
		else $error("error estimate not saturated without conversion");

	a_ok_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.convert_ok |-> result.model_valid)
		else $error("conversion reported on invalid model");

	a_drift_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.model_valid |-> result.drift_ppb == '0)
		else $error("drift reported on invalid model");

endmodule

bind timestamp_clock_sync_model tcs_checker u_tcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timestamp clock sync model. Directed items cover
// reset behavior, field extremes, timestamp wrap, misses past the limit and the
// unused function code. Random runs follow, mostly coherent clock tracks with
// drift, under several register settings. A scoreboard predicts every result
// and checks it field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
	import tcs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FUNC_SPARE = 2'd3;   // unused code, acts as a query
	localparam int HOLD_CYCLES = 3000;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 800;

	// Predicts conversion results and checks the block's transfers in order.
	class clock_sync_scoreboard;
		bit [4:0]  phase_shift;
		bit [15:0] baseline_limit, miss_limit, jitter_ticks;
		bit [TS_BITS-1:0] last_local, last_master;
		longint local_span, master_span, phase_offset;
		int unsigned obs_count, miss_count;
		bit have_first, valid_flag;
		result_t expected_q[$];
		int mismatches, checked, converted;

		function new();
			phase_shift = 4;
			baseline_limit = 128;
			miss_limit = 3;
			jitter_ticks = 64;
			last_local = '0;
			last_master = '0;
			local_span = 0;
			master_span = 0;
			phase_offset = 0;
			obs_count = 0;
			miss_count = 0;
			have_first = 0;
			valid_flag = 0;
			mismatches = 0;
			checked = 0;
			converted = 0;
		endfunction

		function void write_reg(logic [2:0] idx, bit [15:0] val);
			case (idx)
				CFG_PHASE_SHIFT:    phase_shift = val[4:0];
				CFG_BASELINE_LIMIT: baseline_limit = val;
				CFG_MISS_LIMIT:     miss_limit = val;
				CFG_JITTER_TICKS:   jitter_ticks = val;
				default: ;
			endcase
		endfunction

		function longint wrap_delta(bit [TS_BITS-1:0] a, bit [TS_BITS-1:0] b);
			bit [TS_BITS-1:0] d;
			longint r;
			d = a - b;
			r = $signed(d);
			return r;
		endfunction

		function longint div_trunc(longint a, longint b);
			if (b == -1)
				return -a;
			return a / b;
		endfunction

		function bit [63:0] root64(bit [63:0] v);
			bit [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function bit usable();
			return valid_flag && local_span != 0 && miss_count <= miss_limit;
		endfunction

		function bit [TS_BITS-1:0] to_master(bit [TS_BITS-1:0] loc);
			longint d, num, prod, corr;
			bit [63:0] s;
			d = wrap_delta(loc, last_local);
			num = master_span - local_span;
			prod = d * num;
			corr = div_trunc(prod, local_span);
			s = 64'(last_master);
			s = s + d + corr + phase_offset;
			return s[TS_BITS-1:0];
		endfunction

		function bit [31:0] error_est(bit [31:0] ahead);
			bit [63:0] span, rate, avg_n, pt, sr, sp, r;
			if (!usable())
				return '1;
			span = (local_span < 0) ? -local_span : local_span;
			rate = ((64'(jitter_ticks) * 64'd14142 * 64'(ahead)) / 64'd10000) / span;
			avg_n = 64'd1 << phase_shift;
			pt = (64'(jitter_ticks) * 64'd1000) / root64(avg_n * 64'd1000000);
			if (rate > 64'hFFFF_FFFF)
				return '1;
			sr = rate * rate;
			sp = pt * pt;
			if (sr > ~sp)
				return '1;
			r = root64(sr + sp);
			return (r > 64'hFFFF_FFFF) ? '1 : r[31:0];
		endfunction

		function int drift_ppb();
			longint num, q;
			if (!valid_flag || master_span == 0)
				return 0;
			num = (local_span - master_span) * longint'(1000000000);
			q = div_trunc(num, master_span);
			if (q > longint'(32'sh7FFF_FFFF)) q = longint'(32'sh7FFF_FFFF);
			if (q < longint'(32'sh8000_0000)) q = longint'(32'sh8000_0000);
			return int'(q);
		endfunction

		function void observe(bit [TS_BITS-1:0] mts, bit [TS_BITS-1:0] lts);
			if (!have_first) begin
				last_local = lts;
				last_master = mts;
				have_first = 1;
				miss_count = 0;
				return;
			end
			if (usable())
				phase_offset = phase_offset +
					(wrap_delta(mts, to_master(lts)) >>> phase_shift);
			local_span = local_span + wrap_delta(lts, last_local);
			master_span = master_span + wrap_delta(mts, last_master);
			last_local = lts;
			last_master = mts;
			miss_count = 0;
			if (obs_count < 16'hFFFF) obs_count++;
			if (local_span != 0) valid_flag = 1;
			if (obs_count >= baseline_limit) begin
				local_span = local_span / 2;
				master_span = master_span / 2;
				obs_count = obs_count / 2;
			end
		endfunction

		// Apply one item to the model state and queue its expected result.
		function void note_item(item_t it);
			result_t r;
			bit ok;
			if (it.func == FUNC_OBSERVE) begin
				observe(it.master_ts, it.local_ts);
			end else if (it.func == FUNC_MISS) begin
				if (miss_count < 16'hFFFF) miss_count++;
				if (miss_count > miss_limit) valid_flag = 0;
			end
			ok = usable();
			if (ok) converted++;
			r.master_est = ok ? to_master(it.local_ts) : '0;
			r.convert_ok = ok;
			r.error_ticks = error_est(it.ahead_ticks);
			r.drift_ppb = drift_ppb();
			r.model_valid = valid_flag;
			expected_q.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t exp;
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result transfer %p", $realtime, got);
				return;
			end
			exp = expected_q.pop_front();
			if (got.master_est !== exp.master_est || got.convert_ok !== exp.convert_ok ||
			    got.error_ticks !== exp.error_ticks || got.drift_ppb !== exp.drift_ppb ||
			    got.model_valid !== exp.model_valid) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result %0d mismatch\n  exp %p\n  got %p",
						$realtime, checked, exp, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	clock_sync_scoreboard sb;
	bit quiet;
	bit hold_req;
	int items_sent;
	int obs_sent;

	// track of the simulated clocks
	bit [TS_BITS-1:0] trk_master, trk_local;
	int trk_ppm;

	timestamp_clock_sync_model u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Offer one item, sometimes after a random gap; hold it until taken.
	task automatic send_item(item_t it);
		@(negedge clk);
		if (!quiet && $urandom_range(99) < 16) begin
			item_valid = 0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		item_valid = 1;
		item = it;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
		items_sent++;
		if (it.func == FUNC_OBSERVE) obs_sent++;
	endtask

	task automatic send(logic [1:0] f, bit [TS_BITS-1:0] m, bit [TS_BITS-1:0] l,
			bit [31:0] a);
		item_t it;
		it.func = f;
		it.master_ts = m;
		it.local_ts = l;
		it.ahead_ticks = a;
		send_item(it);
	endtask

	task automatic write_reg(logic [2:0] idx, bit [15:0] val);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// Drop the item line and wait until every result is back.
	task automatic wait_idle();
		@(negedge clk);
		item_valid = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_regs(bit [15:0] ps, bit [15:0] bl, bit [15:0] ml, bit [15:0] jt);
		wait_idle();
		write_reg(CFG_PHASE_SHIFT, ps);
		write_reg(CFG_BASELINE_LIMIT, bl);
		write_reg(CFG_MISS_LIMIT, ml);
		write_reg(CFG_JITTER_TICKS, jt);
	endtask

	function automatic bit [TS_BITS-1:0] rand_ts();
		return TS_BITS'({$urandom, $urandom});
	endfunction

	// Advance the simulated clocks by one sync interval.
	task automatic advance_track();
		longint step, lstep;
		step = $urandom_range(2000000, 50000);
		lstep = step + (step * trk_ppm) / 1000000 + $signed($urandom_range(64)) - 32;
		trk_master = trk_master + TS_BITS'(step);
		trk_local = trk_local + TS_BITS'(lstep);
	endtask

	task automatic run_random(int n);
		int k;
		bit [31:0] ahead;
		trk_master = rand_ts();
		trk_local = rand_ts();
		trk_ppm = $signed($urandom_range(400)) - 200;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			ahead = ($urandom_range(3) == 0) ? $urandom : $urandom_range(5000000);
			if (k < 62) begin
				advance_track();
				send(FUNC_OBSERVE, trk_master, trk_local, ahead);
			end else if (k < 70) begin
				advance_track();
				send(FUNC_MISS, rand_ts(), trk_local, ahead);
			end else if (k < 84) begin
				send(($urandom_range(7) == 0) ? FUNC_SPARE : FUNC_QUERY, rand_ts(),
					trk_local + $urandom_range(3000000), ahead);
			end else if (k < 88) begin
				// restart the track somewhere else
				trk_master = rand_ts();
				trk_local = rand_ts();
				trk_ppm = $signed($urandom_range(400)) - 200;
			end else begin
				send(2'($urandom), rand_ts(), rand_ts(), $urandom);
			end
		end
	endtask

	// Pull result transfers, with random stalls and one long hold-off.
	initial begin
		result_stall = 1;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_stall = 1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end
			result_stall = !quiet && $urandom_range(99) < 16;
		end
	end

	always @(posedge clk)
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);

	// End the run if no transfer happens for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
			    (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		quiet = 0;
		hold_req = 0;
		items_sent = 0;
		obs_sent = 0;
		arst_n = 0;
		item_valid = 0;
		item = '0;
		cfg_valid = 0;
		cfg_index = CFG_PHASE_SHIFT;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset state, extremes, wrap, miss limit, spare code
		send(FUNC_QUERY, '0, '0, '0);
		send(FUNC_MISS, '1, '1, '1);
		send(FUNC_OBSERVE, 40'hFF_FFF0_0000, 40'hFF_FFE0_0000, 32'd1000);
		send(FUNC_SPARE, '1, '0, '1);
		send(FUNC_OBSERVE, 40'h00_0001_0000, 40'h00_0000_F000, 32'd0);
		send(FUNC_QUERY, '0, 40'h00_0010_0000, '1);
		send(FUNC_OBSERVE, 40'h00_0011_0000, 40'h00_0010_0100, 32'd500000);
		send(FUNC_OBSERVE, 40'h00_0021_0040, 40'h00_0020_0000, 32'd1);
		send(FUNC_QUERY, '1, '1, 32'h8000_0000);
		send(FUNC_QUERY, '0, '0, '0);
		for (int i = 0; i < 4; i++)
			send(FUNC_MISS, '0, 40'h00_0030_0000, 32'd100000);
		send(FUNC_OBSERVE, 40'h00_0041_0000, 40'h00_0040_0000, 32'd100000);
		send(FUNC_OBSERVE, 40'h80_0000_0000, 40'h7F_FFFF_FFFF, '1);
		send(FUNC_OBSERVE, 40'h80_0000_0000, 40'h7F_FFFF_FFFF, 32'd7);
		send(FUNC_OBSERVE, '0, '1, 32'h0000_FFFF);
		send(FUNC_SPARE, '0, 40'h55_5555_5555, 32'hAAAA_AAAA);
		send(FUNC_QUERY, '1, 40'hAA_AAAA_AAAA, 32'h5555_5555);

		// smallest limits and jitter; receiver holds off while the block stalls items
		set_regs(16'd0, 16'd2, 16'd0, 16'd0);
		hold_req = 1;
		run_random(380);

		// large settings
		set_regs(16'd16, 16'd65535, 16'd65534, 16'd65535);
		run_random(380);

		// no idling on either side in this stretch
		set_regs(16'd4, 16'd8, 16'd3, 16'd1000);
		quiet = 1;
		run_random(380);
		quiet = 0;

		set_regs(16'($urandom_range(16)), 16'($urandom_range(65535, 2)), 16'd1,
			16'($urandom));
		run_random(450);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d items sent (%0d observations), %0d results checked, %0d converted",
			items_sent, obs_sent, sb.checked, sb.converted);
		$display("five register settings, %0d mismatches, %0d results outstanding",
			sb.mismatches, sb.expected_q.size());
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
